/* src/fnif_pkg.sv */
// Shared constants, types and helpers for the four-neighbor impulse filter.
`timescale 1ns / 1ps
`default_nettype none
package fnif_pkg;

	localparam int COL_W      = 6;
	localparam int ROW_W      = 10;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int DEF_MAX_COLS   = 32;
	localparam int DEF_PIXEL_BITS = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd2;

	localparam logic [COL_W-1:0] RST_FRAME_WIDTH    = 6'd30;
	localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT   = 10'd20;
	localparam logic [THR_W-1:0] RST_DIFF_THRESHOLD = 8'd1;

	// one queued pixel job: where it sits and what it triggers
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             row_nz;
		logic             row_gt1;
		logic             last_col;
		logic             last_row;
	} cmd_t;

	function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
		eff_height = (h == '0) ? ROW_W'(1) : h;
	endfunction

endpackage
`default_nettype wire

/* src/fnif_front.sv */
// Front end: tracks frame position and classifies each accepted pixel.
`timescale 1ns / 1ps
`default_nettype none
module fnif_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [fnif_pkg::COL_W-1:0] eff_w,
	input  wire logic [fnif_pkg::ROW_W-1:0] eff_h,
	input  wire logic                      restart,
	input  wire logic                      q_full,
	output logic                           push,
	output fnif_pkg::cmd_t                 cmd
);
	logic [fnif_pkg::COL_W-1:0] col_q, col_c, col_p1;
	logic [fnif_pkg::ROW_W-1:0] row_q, row_c, row_p1;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		col_c  = (col_q >= eff_w) ? eff_w - 1'b1 : col_q;
		row_c  = (row_q >= eff_h) ? eff_h - 1'b1 : row_q;
		col_p1 = col_c + 1'b1;
		row_p1 = row_c + 1'b1;
		cmd.col      = col_c;
		cmd.row_nz   = (row_c != '0);
		cmd.row_gt1  = (row_c > fnif_pkg::ROW_W'(1));
		cmd.last_col = (col_p1 == eff_w);
		cmd.last_row = (row_p1 == eff_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (cmd.last_col) begin
				col_q <= '0;
				row_q <= cmd.last_row ? '0 : row_p1;
			end else begin
				col_q <= col_p1;
				row_q <= row_c;
			end
		end
	end

endmodule
`default_nettype wire

/* src/fnif_fifo.sv */
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module fnif_fifo #(
	parameter int W = $bits(fnif_pkg::cmd_t) + fnif_pkg::DEF_PIXEL_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              valid,
	output logic [W-1:0]      rdata
);
	logic [W-1:0] mem_q [2];
	logic [1:0]   cnt_q;
	logic         wp_q, rp_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

/* src/fnif_back.sv */
// Back end: row buffers, neighbor test, rounded mean and output register.
`timescale 1ns / 1ps
`default_nettype none
module fnif_back #(
	parameter int MAX_COLS   = fnif_pkg::DEF_MAX_COLS,
	parameter int PIXEL_BITS = fnif_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	output logic                            q_pop,
	input  wire fnif_pkg::cmd_t             q_cmd,
	input  wire logic [PIXEL_BITS-1:0]      q_pixel,
	input  wire logic [fnif_pkg::COL_W-1:0] eff_w,
	input  wire logic [fnif_pkg::THR_W-1:0] thr,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [PIXEL_BITS-1:0]           pixel_out,
	output logic                            replaced,
	output logic                            last_of_run,
	output logic                            end_of_frame
);
	localparam int P      = PIXEL_BITS;
	localparam int CW     = fnif_pkg::COL_W;
	localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RAW_D  = 2 * MAX_COLS;
	localparam int RAW_AW = $clog2(RAW_D);
	localparam int SUM_W  = P + 2;
	localparam int DK     = SUM_W + 2;
	localparam logic [DK:0] DIV3_M = (DK + 1)'((64'd1 << DK) / 64'd3);
	localparam int PROD_W = SUM_W + DK + 1;
	localparam int CMP_W  = (P > fnif_pkg::THR_W) ? P : fnif_pkg::THR_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WR   = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]     st_q;
	logic           bank_q, below_q, up_q, flush_q, out_valid_q;
	logic [CW-1:0]  col_q, col_p1, col_m1;
	logic [P-1:0]   pix_q;
	fnif_pkg::cmd_t cmd_q;

	logic [P-1:0] raw_mem [RAW_D];
	logic [P-1:0] fp_mem [MAX_COLS];

	logic [P-1:0] ctr_s1, rgt_s1, up_s1, lft_s1;
	logic [SUM_W-1:0] sum_s2;
	logic [2:0]       cnt_s2;
	logic             keep_s2;
	logic [P-1:0]     ctr_s2;
	logic [PROD_W-1:0] prod_s3;

	logic [RAW_AW-1:0] a_wr, a_ctr, a_rgt;
	logic has_right, has_left, out_free, col_end;
	logic [SUM_W-1:0] sum_c;
	logic [2:0]       cnt_c;
	logic             keep_c;
	logic [SUM_W-1:0] q_est, r_est, q_c;
	logic [2:0]       rem_c;
	logic             round_up;
	logic [P-1:0]     mean_c, value_c;
	logic             repl_c;

	function automatic logic [RAW_AW-1:0] raw_addr(input logic bank, input logic [CW-1:0] col);
		raw_addr = (bank ? RAW_AW'(MAX_COLS) : RAW_AW'(0)) + RAW_AW'(col);
	endfunction

	function automatic logic near(input logic [P-1:0] a, input logic [P-1:0] b,
			input logic [fnif_pkg::THR_W-1:0] t);
		logic [P-1:0] d;
		d = (a > b) ? a - b : b - a;
		near = (CMP_W'(d) <= CMP_W'(t));
	endfunction

	assign col_p1  = col_q + 1'b1;
	assign col_m1  = col_q - 1'b1;
	assign col_end = (col_p1 == eff_w);
	assign a_wr    = raw_addr(~bank_q, cmd_q.col);
	assign a_ctr   = raw_addr(bank_q, col_q);
	assign a_rgt   = raw_addr(bank_q, col_p1);
	assign q_pop   = (st_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || !out_stall;

	// neighbor gather: below (raw), right (raw), up and left (filtered)
	always_comb begin
		has_right = (col_p1 < eff_w);
		has_left  = (col_q != '0);
		cnt_c = {2'b0, below_q} + {2'b0, has_right} + {2'b0, up_q} + {2'b0, has_left};
		sum_c = (below_q   ? SUM_W'(pix_q)  : '0) + (has_right ? SUM_W'(rgt_s1) : '0)
		      + (up_q      ? SUM_W'(up_s1)  : '0) + (has_left  ? SUM_W'(lft_s1) : '0);
		keep_c = (below_q && near(ctr_s1, pix_q, thr)) || (has_right && near(ctr_s1, rgt_s1, thr))
		      || (up_q && near(ctr_s1, up_s1, thr)) || (has_left && near(ctr_s1, lft_s1, thr));
	end

	// mean with round half to even; divide by three via reciprocal and one fixup
	always_comb begin
		q_est = SUM_W'(prod_s3 >> DK);
		r_est = sum_s2 - ((q_est << 1) + q_est);
		q_c   = sum_s2;
		rem_c = '0;
		case (cnt_s2)
			3'd2: begin
				q_c   = sum_s2 >> 1;
				rem_c = {2'b0, sum_s2[0]};
			end
			3'd3: begin
				if (r_est >= SUM_W'(3)) begin
					q_c   = q_est + 1'b1;
					rem_c = 3'(r_est - SUM_W'(3));
				end else begin
					q_c   = q_est;
					rem_c = 3'(r_est);
				end
			end
			3'd4: begin
				q_c   = sum_s2 >> 2;
				rem_c = {1'b0, sum_s2[1:0]};
			end
			default: begin
				q_c   = sum_s2;
				rem_c = '0;
			end
		endcase
		round_up = ({rem_c, 1'b0} > {1'b0, cnt_s2})
		        || (({rem_c, 1'b0} == {1'b0, cnt_s2}) && q_c[0]);
		mean_c  = P'(q_c + SUM_W'(round_up));
		repl_c  = (cnt_s2 != '0) && !keep_s2;
		value_c = repl_c ? mean_c : ctr_s2;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WR) raw_mem[a_wr] <= pix_q;
		if (st_q == ST_RD) begin
			ctr_s1 <= raw_mem[a_ctr];
			rgt_s1 <= raw_mem[a_rgt];
			up_s1  <= fp_mem[col_q[CIDX_W-1:0]];
			lft_s1 <= fp_mem[col_m1[CIDX_W-1:0]];
		end
		if (st_q == ST_OUT && out_free) fp_mem[col_q[CIDX_W-1:0]] <= value_c;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_q <= q_pixel;
			cmd_q <= q_cmd;
		end
		if (st_q == ST_SUM) begin
			sum_s2  <= sum_c;
			cnt_s2  <= cnt_c;
			keep_s2 <= keep_c;
			ctr_s2  <= ctr_s1;
		end
		if (st_q == ST_MUL) prod_s3 <= PROD_W'(sum_s2) * PROD_W'(DIV3_M);
		if (st_q == ST_OUT && out_free) begin
			pixel_out    <= value_c;
			replaced     <= repl_c;
			last_of_run  <= flush_q ? col_end : !(cmd_q.last_col && cmd_q.last_row);
			end_of_frame <= flush_q && col_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			bank_q      <= 1'b0;
			col_q       <= '0;
			below_q     <= 1'b0;
			up_q        <= 1'b0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) st_q <= ST_WR;
				end
				ST_WR: begin
					if (cmd_q.row_nz) begin
						col_q   <= cmd_q.col;
						below_q <= 1'b1;
						up_q    <= cmd_q.row_gt1;
						flush_q <= 1'b0;
						st_q    <= ST_RD;
					end else begin
						if (cmd_q.last_col) bank_q <= ~bank_q;
						if (cmd_q.last_col && cmd_q.last_row) begin
							col_q   <= '0;
							below_q <= 1'b0;
							up_q    <= 1'b0;
							flush_q <= 1'b1;
							st_q    <= ST_RD;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_RD:  st_q <= ST_SUM;
				ST_SUM: st_q <= ST_MUL;
				ST_MUL: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						if (!flush_q) begin
							if (cmd_q.last_col) bank_q <= ~bank_q;
							if (cmd_q.last_col && cmd_q.last_row) begin
								col_q   <= '0;
								below_q <= 1'b0;
								up_q    <= cmd_q.row_nz;
								flush_q <= 1'b1;
								st_q    <= ST_RD;
							end else begin
								st_q <= ST_IDLE;
							end
						end else if (col_end) begin
							flush_q <= 1'b0;
							st_q    <= ST_IDLE;
						end else begin
							col_q <= col_p1;
							st_q  <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* src/four_neighbor_impulse_filter_core.sv */
// Top level of the four-neighbor impulse noise filter.
// Usage:
//   Input channel (in_valid / in_stall / pixel_in) takes raw pixels of a frame in
//   raster order. Output channel (out_valid / out_stall / pixel_out, replaced,
//   last_of_run, end_of_frame) gives each pixel once the pixel below it arrived;
//   the frame's last input also flushes the whole last row.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets
//   frame_width (0), frame_height (1) and diff_threshold (2); write only while
//   idle. A geometry write restarts the frame position.
// Sequencing:
//   A pixel with a pixel above it goes through the back end's steps in order
//   (queue pop, row write, buffer read, neighbor sum, divide, output); the back
//   end pops no new pixel until it is done with the last, and first-row pixels
//   stop after the row write. The final-row flush runs read, sum, divide and
//   output once per column. A two-deep queue decouples the back end's sequencer
//   from the input side, which stalls when the queue is full.
// Reset: position, queue and output go empty; registers return to 30 x 20,
//   threshold 1. A stalled output word holds and the back end waits on it.
`timescale 1ns / 1ps
`default_nettype none
module four_neighbor_impulse_filter_core #(
	parameter int MAX_COLS   = fnif_pkg::DEF_MAX_COLS,
	parameter int PIXEL_BITS = fnif_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [PIXEL_BITS-1:0]           pixel_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [PIXEL_BITS-1:0]                pixel_out,
	output logic                                 replaced,
	output logic                                 last_of_run,
	output logic                                 end_of_frame,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fnif_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fnif_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int QW = $bits(fnif_pkg::cmd_t) + PIXEL_BITS;

	logic [fnif_pkg::COL_W-1:0] width_q, eff_w;
	logic [fnif_pkg::ROW_W-1:0] height_q, eff_h;
	logic [fnif_pkg::THR_W-1:0] thr_q;
	logic cfg_we, restart, push, q_full, q_valid, q_pop;
	fnif_pkg::cmd_t cmd_f, cmd_b;
	logic [QW-1:0] q_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign restart   = cfg_we && ((cfg_index == fnif_pkg::CFG_FRAME_WIDTH)
	                           || (cfg_index == fnif_pkg::CFG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fnif_pkg::RST_FRAME_WIDTH;
			height_q <= fnif_pkg::RST_FRAME_HEIGHT;
			thr_q    <= fnif_pkg::RST_DIFF_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				fnif_pkg::CFG_FRAME_WIDTH:    width_q  <= cfg_data[fnif_pkg::COL_W-1:0];
				fnif_pkg::CFG_FRAME_HEIGHT:   height_q <= cfg_data;
				fnif_pkg::CFG_DIFF_THRESHOLD: thr_q    <= cfg_data[fnif_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) eff_w = fnif_pkg::COL_W'(1);
		else if (width_q > fnif_pkg::COL_W'(MAX_COLS)) eff_w = fnif_pkg::COL_W'(MAX_COLS);
		else eff_w = width_q;
		eff_h = fnif_pkg::eff_height(height_q);
	end

	fnif_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.restart  (restart),
		.q_full   (q_full),
		.push     (push),
		.cmd      (cmd_f)
	);

	fnif_fifo #(.W(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({cmd_f, pixel_in}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign cmd_b = q_rdata[QW-1:PIXEL_BITS];

	fnif_back #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_cmd        (cmd_b),
		.q_pixel      (q_rdata[PIXEL_BITS-1:0]),
		.eff_w        (eff_w),
		.thr          (thr_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out),
		.replaced     (replaced),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

	// the frame's final word always closes its run
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> last_of_run)
		else $error("end_of_frame without last_of_run");

	// a word pushed into an empty queue is visible to the back end next cycle
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_valid |=> q_valid)
		else $error("queued word lost");

	// the back end never pops an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule
`default_nettype wire
